@@ rtl/rcpw_pkg.sv @@
// ----------------------------------------------------------------------------
// rcpw_pkg
// Shared constants for the raised cosine packet window unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpw_pkg;

    localparam int MAX_HALF_LENGTH_DEF  = 8192;
    localparam int COS_TABLE_DEPTH_DEF  = 1024;
    localparam int WINDOW_FRAC_BITS_DEF = 16;

    localparam int SAMPLE_W = 16;
    localparam int HALF_W   = 14;
    localparam int STEP_W   = 32;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [HALF_W-1:0] HALF_LENGTH_RST = 14'd64;
    localparam logic [STEP_W-1:0] PHASE_STEP_RST  = 32'd33818640;

    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef enum logic {
        REG_HALF_LENGTH = 1'b0,
        REG_PHASE_STEP  = 1'b1
    } t_reg_sel;

endpackage

`default_nettype wire

@@ rtl/rcpw_cos_rom.sv @@
// ----------------------------------------------------------------------------
// rcpw_cos_rom
// Quarter-wave cosine ROM, unsigned with WINDOW_FRAC_BITS fraction bits,
// COS_TABLE_DEPTH+1 entries, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpw_cos_rom #(
    parameter int COS_TABLE_DEPTH  = rcpw_pkg::COS_TABLE_DEPTH_DEF,
    parameter int WINDOW_FRAC_BITS = rcpw_pkg::WINDOW_FRAC_BITS_DEF,
    localparam int IDX_W = $clog2(COS_TABLE_DEPTH + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [IDX_W-1:0]            i_addr,
    output logic      [WINDOW_FRAC_BITS:0]   o_data
);

    typedef logic [WINDOW_FRAC_BITS:0] t_rom [COS_TABLE_DEPTH+1];

    localparam longint DIV_N7 = rcpw_pkg::Q30_ONE * 64'sd182;
    localparam longint DIV_N6 = rcpw_pkg::Q30_ONE * 64'sd132;
    localparam longint DIV_N5 = rcpw_pkg::Q30_ONE * 64'sd90;
    localparam longint DIV_N4 = rcpw_pkg::Q30_ONE * 64'sd56;
    localparam longint DIV_N3 = rcpw_pkg::Q30_ONE * 64'sd30;
    localparam longint DIV_N2 = rcpw_pkg::Q30_ONE * 64'sd12;
    localparam longint DIV_N1 = rcpw_pkg::Q30_ONE * 64'sd2;

    function automatic t_rom build_rom();
        t_rom   rom;
        longint x;
        longint x2;
        longint r;
        longint e;
        longint one_f;
        int     i;
        one_f = longint'(1) <<< WINDOW_FRAC_BITS;
        for (i = 0; i <= COS_TABLE_DEPTH; i++) begin
            x  = (longint'(i) * rcpw_pkg::HALF_PI_Q30) / COS_TABLE_DEPTH;
            x2 = (x * x) / rcpw_pkg::Q30_ONE;
            r  = rcpw_pkg::Q30_ONE;
            r  = rcpw_pkg::Q30_ONE - (x2 * r) / DIV_N7;
            r  = rcpw_pkg::Q30_ONE - (x2 * r) / DIV_N6;
            r  = rcpw_pkg::Q30_ONE - (x2 * r) / DIV_N5;
            r  = rcpw_pkg::Q30_ONE - (x2 * r) / DIV_N4;
            r  = rcpw_pkg::Q30_ONE - (x2 * r) / DIV_N3;
            r  = rcpw_pkg::Q30_ONE - (x2 * r) / DIV_N2;
            r  = rcpw_pkg::Q30_ONE - (x2 * r) / DIV_N1;
            if (r < 0) begin
                r = 0;
            end
            e = (r + (longint'(1) <<< (29 - WINDOW_FRAC_BITS))) >>> (30 - WINDOW_FRAC_BITS);
            if (e > one_f) begin
                e = one_f;
            end
            rom[i] = e[WINDOW_FRAC_BITS:0];
        end
        return rom;
    endfunction

    localparam t_rom COS_ROM = build_rom();

    logic [WINDOW_FRAC_BITS:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= COS_ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

@@ rtl/raised_cosine_packet_window_unit.sv @@
// ----------------------------------------------------------------------------
// raised_cosine_packet_window_unit
// Odd-length Hann window over pitch packets of 2P-1 signed 16-bit samples.
// ----------------------------------------------------------------------------
// Takes one word per clock unless the output stalls, and returns one word per
// input. The result passes three registered stages and is taken when the
// output side is ready: one stage registers the table address from
// the window phase, one covers the registered cosine ROM read, and one holds
// the product in the output register. Each stage advances independently, so
// the input stays ready while the output register is stalled until all three
// stages are full. The user must write half_length and phase_step over APB
// only while the stream is idle; the block itself does not enforce this. The window
// phase restarts at phase_step/2 after the last word of each packet, which is flagged on tlast.
`default_nettype none

module raised_cosine_packet_window_unit #(
    parameter int MAX_HALF_LENGTH  = rcpw_pkg::MAX_HALF_LENGTH_DEF,
    parameter int COS_TABLE_DEPTH  = rcpw_pkg::COS_TABLE_DEPTH_DEF,
    parameter int WINDOW_FRAC_BITS = rcpw_pkg::WINDOW_FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // APB configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [rcpw_pkg::APB_AW-1:0]     paddr,
    input  wire logic [rcpw_pkg::APB_DW-1:0]     pwdata,
    output logic      [rcpw_pkg::APB_DW-1:0]     prdata,
    output logic                                 pready,
    // input stream
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [rcpw_pkg::SAMPLE_W-1:0]   i_s_tdata,   // [15:0] sample
    // output stream
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic      [rcpw_pkg::SAMPLE_W-1:0]   o_m_tdata,   // [15:0] windowed_sample
    output logic                                 o_m_tlast
);

    localparam int SW    = rcpw_pkg::SAMPLE_W;
    localparam int HW    = rcpw_pkg::HALF_W;
    localparam int STW   = rcpw_pkg::STEP_W;
    localparam int F     = WINDOW_FRAC_BITS;
    localparam int IDX_W = $clog2(COS_TABLE_DEPTH + 1);
    localparam int MUL_W = 30 + IDX_W;
    localparam int POS_W = $clog2(2 * MAX_HALF_LENGTH - 1);
    localparam int PL_W  = $clog2(MAX_HALF_LENGTH + 1);
    localparam int P_W   = (PL_W > HW) ? PL_W : HW;
    localparam int PRD_W = SW + 1 + F + 2;

    // configuration
    logic [HW-1:0]  r_half_length;
    logic [STW-1:0] r_phase_step;
    logic           w_cfg_wr;
    rcpw_pkg::t_reg_sel w_sel;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_sel    = rcpw_pkg::t_reg_sel'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_length <= rcpw_pkg::HALF_LENGTH_RST;
            r_phase_step  <= rcpw_pkg::PHASE_STEP_RST;
        end else if (w_cfg_wr) begin
            unique case (w_sel)
                rcpw_pkg::REG_HALF_LENGTH: r_half_length <= pwdata[HW-1:0];
                rcpw_pkg::REG_PHASE_STEP:  r_phase_step  <= pwdata[STW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_sel)
            rcpw_pkg::REG_HALF_LENGTH: prdata = {{(rcpw_pkg::APB_DW-HW){1'b0}}, r_half_length};
            rcpw_pkg::REG_PHASE_STEP:  prdata = r_phase_step;
            default:                   prdata = '0;
        endcase
    end

    // pipeline handshake
    logic r_v1, r_v2, r_vo;
    logic w_adv_o, w_adv2, w_adv1, w_acc;

    assign w_adv_o    = !r_vo || i_m_tready;
    assign w_adv2     = !r_v2 || w_adv_o;
    assign w_adv1     = !r_v1 || w_adv2;
    assign o_s_tready = w_adv1;
    assign w_acc      = i_s_tvalid && o_s_tready;

    // packet position and window phase
    logic [STW-1:0]   r_phase;
    logic [POS_W-1:0] r_pos;
    logic [STW-1:0]   n_phase;
    logic [POS_W-1:0] n_pos;
    logic [P_W-1:0]   w_p;
    logic [P_W:0]     w_last_pos;
    logic             w_last;

    always_comb begin
        w_p = P_W'(r_half_length);
        if (w_p == '0) begin
            w_p = P_W'(1);
        end else if (w_p > P_W'(MAX_HALF_LENGTH)) begin
            w_p = P_W'(MAX_HALF_LENGTH);
        end
    end

    assign w_last_pos = {w_p, 1'b0} - (P_W+1)'(2);
    assign w_last     = (P_W+1)'(r_pos) >= w_last_pos;

    always_comb begin
        if (w_last) begin
            n_phase = r_phase_step >> 1;
            n_pos   = '0;
        end else begin
            n_phase = r_phase + r_phase_step;
            n_pos   = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rcpw_pkg::PHASE_STEP_RST >> 1;
            r_pos   <= '0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
        end
    end

    // table address from current phase
    logic [MUL_W-1:0] w_scaled;
    logic [IDX_W-1:0] w_idx;
    logic [IDX_W-1:0] w_addr;

    assign w_scaled = MUL_W'(r_phase[29:0]) * MUL_W'(COS_TABLE_DEPTH)
                    + (MUL_W'(1) << 29);
    assign w_idx    = w_scaled[MUL_W-1:30];
    assign w_addr   = r_phase[30] ? (IDX_W'(COS_TABLE_DEPTH) - w_idx) : w_idx;

    // stage 1
    logic [SW-1:0]    r_smp1;
    logic [IDX_W-1:0] r_addr1;
    logic [1:0]       r_quad1;
    logic             r_last1;

    // stage 2
    logic [SW-1:0]    r_smp2;
    logic [1:0]       r_quad2;
    logic             r_last2;
    logic [F:0]       w_cos2;

    // window and product
    logic [F+1:0]   w_win;
    logic           w_neg;
    logic [SW:0]    w_mag;
    logic [PRD_W-1:0] w_prod;
    logic [SW:0]    w_res;
    logic [SW-1:0]  n_data_o;

    // output
    logic [SW-1:0]    r_data_o;
    logic             r_last_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= w_acc;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
            if (w_adv_o) begin
                r_vo <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_smp1  <= i_s_tdata;
            r_addr1 <= w_addr;
            r_quad1 <= r_phase[31:30];
            r_last1 <= w_last;
        end
        if (w_adv2 && r_v1) begin
            r_smp2  <= r_smp1;
            r_quad2 <= r_quad1;
            r_last2 <= r_last1;
        end
        if (w_adv_o && r_v2) begin
            r_data_o <= n_data_o;
            r_last_o <= r_last2;
        end
    end

    rcpw_cos_rom #(
        .COS_TABLE_DEPTH  (COS_TABLE_DEPTH),
        .WINDOW_FRAC_BITS (WINDOW_FRAC_BITS)
    ) u_cos_rom (
        .i_clk  (i_clk),
        .i_en   (w_adv2 && r_v1),
        .i_addr (r_addr1),
        .o_data (w_cos2)
    );

    always_comb begin
        if (r_quad2 == 2'd1 || r_quad2 == 2'd2) begin
            w_win = (F+2)'(1 << F) + (F+2)'(w_cos2);
        end else begin
            w_win = (F+2)'(1 << F) - (F+2)'(w_cos2);
        end
    end

    assign w_neg    = r_smp2[SW-1];
    assign w_mag    = w_neg ? ((SW+1)'(0) - {1'b1, r_smp2}) : {1'b0, r_smp2};
    assign w_prod   = PRD_W'(w_mag) * PRD_W'(w_win);
    assign w_res    = w_prod[F+1+SW:F+1];
    assign n_data_o = w_neg ? SW'((SW+1)'(0) - w_res) : w_res[SW-1:0];

    assign o_m_tvalid = r_vo;
    assign o_m_tdata  = r_data_o;
    assign o_m_tlast  = r_last_o;

    // checks
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_last) |=> (r_pos == '0 && r_phase == ($past(r_phase_step) >> 1)))
        else $error("packet restart did not reload phase and position");

    a_pos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_last) |=> (r_pos == $past(r_pos) + POS_W'(1)))
        else $error("position did not advance");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(2 * MAX_HALF_LENGTH - 2))
        else $error("position beyond longest packet");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_v1 && r_v2 && r_vo && !i_m_tready))
        else $error("input stalled with room in the pipeline");

    a_hold_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !w_adv2) |=> (r_v2 && $stable(r_smp2) && $stable(r_last2)))
        else $error("stalled stage lost its word");

endmodule

`default_nettype wire

@@ tb/raised_cosine_packet_window_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raised_cosine_packet_window_unit_tb
// Self-checking bench for the odd-length Hann packet window unit.
// ----------------------------------------------------------------------------
// Streams signed samples under bursty input and a patterned output stall.
// Each accepted word runs through a local fixed-point model of the window:
// the cosine table, the phase walk and the packet count. Every result word is
// compared with the oldest prediction. The configuration is rewritten over
// APB between phases, once the stream has drained. The settings include the
// zero, saturated and lowered half lengths, and matched and mismatched phase
// steps.
// ----------------------------------------------------------------------------

module raised_cosine_packet_window_unit_tb;

    localparam int COS_DEPTH      = rcpw_pkg::COS_TABLE_DEPTH_DEF;
    localparam int FRAC_BITS      = rcpw_pkg::WINDOW_FRAC_BITS_DEF;
    localparam int MAX_P          = rcpw_pkg::MAX_HALF_LENGTH_DEF;
    localparam int SAMPLE_W       = rcpw_pkg::SAMPLE_W;
    localparam int HALF_W         = rcpw_pkg::HALF_W;
    localparam int STEP_W         = rcpw_pkg::STEP_W;
    localparam int APB_AW         = rcpw_pkg::APB_AW;
    localparam int APB_DW         = rcpw_pkg::APB_DW;
    localparam int RESULT_LATENCY = 3;
    localparam int RANDOM_WORDS   = 950;

    typedef struct packed {
        logic [SAMPLE_W-1:0] windowed;
        logic                last;
    } t_windowed_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    wire  [APB_DW-1:0]   prdata;
    wire                 pready;
    logic                i_s_tvalid = 1'b0;
    wire                 o_s_tready;
    logic [SAMPLE_W-1:0] i_s_tdata = '0;    // [15:0] sample
    wire                 o_m_tvalid;
    logic                i_m_tready = 1'b0;
    wire  [SAMPLE_W-1:0] o_m_tdata;         // [15:0] windowed_sample
    wire                 o_m_tlast;

    raised_cosine_packet_window_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    int                cos_rom [0:COS_DEPTH];
    logic [HALF_W-1:0] model_half;
    logic [STEP_W-1:0] model_step;
    logic [STEP_W-1:0] model_phase;
    logic [HALF_W-1:0] model_pos;

    t_windowed_word pending_windowed [$];
    int mismatch_count = 0;
    int words_sent = 0;
    int burst_left = 0;
    int rx_cycle = 0;
    int rx_hold = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

    function automatic void build_cos_rom();
        longint x, x2, r, d, e;
        for (int i = 0; i <= COS_DEPTH; i++) begin
            x  = (longint'(i) * rcpw_pkg::HALF_PI_Q30) / COS_DEPTH;
            x2 = (x * x) / rcpw_pkg::Q30_ONE;
            r  = rcpw_pkg::Q30_ONE;
            for (int n = 7; n >= 1; n--) begin
                d = longint'(2 * n) * longint'(2 * n - 1);
                r = rcpw_pkg::Q30_ONE - (x2 * r) / (rcpw_pkg::Q30_ONE * d);
            end
            if (r < 0) begin
                r = 0;
            end
            e = (r + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
            if (e > (64'sd1 << FRAC_BITS)) begin
                e = 64'sd1 << FRAC_BITS;
            end
            cos_rom[i] = int'(e);
        end
    endfunction

    // 2^F - cos(phase), 0 .. 2^(F+1)
    function automatic int window_twice_weight(logic [STEP_W-1:0] ph);
        longint idx_l;
        int     idx;
        int     mag;
        int     one;
        idx_l = (longint'(ph[29:0]) * COS_DEPTH + (64'sd1 << 29)) >>> 30;
        idx   = (idx_l > COS_DEPTH) ? COS_DEPTH : int'(idx_l);
        mag   = ph[30] ? cos_rom[COS_DEPTH - idx] : cos_rom[idx];
        one   = 1 << FRAC_BITS;
        return (ph[31] ^ ph[30]) ? one + mag : one - mag;
    endfunction

    function automatic int effective_half(int half);
        int p;
        p = half;
        if (p == 0) begin
            p = 1;
        end
        if (p > MAX_P) begin
            p = MAX_P;
        end
        return p;
    endfunction

    function automatic logic [STEP_W-1:0] matched_step(int half);
        longint q;
        int     p;
        p = effective_half(half);
        if (p == 1) begin
            return '1;
        end
        q = (64'sd1 <<< 32) / (2 * p - 1);
        return q[STEP_W-1:0];
    endfunction

    function automatic t_windowed_word predict_windowed(logic [SAMPLE_W-1:0] s);
        int             p;
        int             last_pos;
        int             mag;
        longint         prod;
        t_windowed_word w;
        p        = effective_half(int'(model_half));
        last_pos = 2 * p - 2;
        mag      = s[SAMPLE_W-1] ? 65536 - int'(s) : int'(s);
        prod     = (longint'(mag) * window_twice_weight(model_phase)) >>> (FRAC_BITS + 1);
        if (s[SAMPLE_W-1]) begin
            prod = -prod;
        end
        w.windowed = prod[SAMPLE_W-1:0];
        w.last     = int'(model_pos) >= last_pos;
        if (w.last) begin
            model_phase = model_step >> 1;
            model_pos   = '0;
        end else begin
            model_phase = model_phase + model_step;
            model_pos   = model_pos + 1'b1;
        end
        return w;
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            case ($urandom_range(0, 3))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end else if (r == 1) begin
            return SAMPLE_W'($urandom_range(0, 15) - 8);
        end
        return SAMPLE_W'($urandom);
    endfunction

    task automatic reset_model();
        model_half  = rcpw_pkg::HALF_LENGTH_RST;
        model_step  = rcpw_pkg::PHASE_STEP_RST;
        model_phase = rcpw_pkg::PHASE_STEP_RST >> 1;
        model_pos   = '0;
    endtask

    task automatic note_mismatch(string what, t_windowed_word want, t_windowed_word got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t mismatch, %s: expected data=%h last=%b, got data=%h last=%b",
                     $realtime, what, want.windowed, want.last, got.windowed, got.last);
        end
    endtask

    task automatic apb_write(rcpw_pkg::t_reg_sel sel, logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (sel == rcpw_pkg::REG_HALF_LENGTH) begin
            model_half = value[HALF_W-1:0];
        end else begin
            model_step = value;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_sample(logic [SAMPLE_W-1:0] s);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0) begin
                gap = 0;
            end else if ($urandom_range(0, 9) == 0) begin
                gap = $urandom_range(10, 25);
            end else begin
                gap = $urandom_range(1, 6);
            end
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= s;
        do @(posedge i_clk); while (!o_s_tready);
        pending_windowed.push_back(predict_windowed(s));
        words_sent++;
        @(negedge i_clk);
    endtask

    // hold the input idle until every predicted word has come out
    task automatic drain_results();
        int guard;
        guard = 0;
        i_s_tvalid <= 1'b0;
        while (pending_windowed.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (RESULT_LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic set_packet(logic [APB_DW-1:0] half_word, logic [STEP_W-1:0] step);
        drain_results();
        apb_write(rcpw_pkg::REG_HALF_LENGTH, half_word);
        apb_write(rcpw_pkg::REG_PHASE_STEP, step);
    endtask

    task automatic test_reset_extremes();
        logic [SAMPLE_W-1:0] vals [10];
        vals = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
                 16'h5555, 16'hAAAA, 16'h7FFE, 16'h8001, 16'h1234};
        foreach (vals[i]) begin
            send_sample(vals[i]);
        end
    endtask

    task automatic test_half_length_zero();
        set_packet(32'd0, '1);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(random_sample());
    endtask

    task automatic test_saturation_and_early_end();
        set_packet({18'h3FFFF, 14'h3FFF}, matched_step(16383));
        repeat (4) send_sample(random_sample());
        drain_results();
        apb_write(rcpw_pkg::REG_HALF_LENGTH, 32'd2);
        repeat (4) send_sample(random_sample());
    endtask

    task automatic test_step_change_mid_packet();
        set_packet(32'd4, matched_step(4));
        repeat (2) send_sample(random_sample());
        drain_results();
        apb_write(rcpw_pkg::REG_PHASE_STEP, $urandom);
        repeat (6) send_sample(random_sample());
    endtask

    task automatic test_random_packets();
        int               target;
        int               half;
        int               p;
        int               count;
        int               r;
        logic [STEP_W-1:0] step;
        logic [APB_DW-1:0] half_word;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            r = $urandom_range(0, 9);
            if (r <= 5) begin
                half = $urandom_range(1, 12);
            end else if (r <= 7) begin
                half = $urandom_range(13, 100);
            end else if (r == 8) begin
                half = $urandom_range(8000, 16383);
            end else begin
                half = 0;
            end
            p = effective_half(half);
            r = $urandom_range(0, 9);
            if (r <= 6) begin
                step = matched_step(half);
            end else if (r == 7) begin
                step = $urandom;
            end else if (r == 8) begin
                step = matched_step(half) ^ (32'd1 << $urandom_range(0, 31));
            end else begin
                step = $urandom_range(0, 1) ? '1 : '0;
            end
            half_word = {($urandom_range(0, 3) == 0) ? 18'($urandom) : 18'd0, 14'(half)};
            if (p > 200) begin
                count = $urandom_range(20, 120);
            end else if ($urandom_range(0, 9) < 7) begin
                count = $urandom_range(1, 4) * (2 * p - 1);
                if (count > 200) begin
                    count = 200;
                end
            end else begin
                count = $urandom_range(1, 40);
            end
            set_packet(half_word, step);
            for (int i = 0; i < count; i++) begin
                if (i == count / 2 && $urandom_range(0, 5) == 0) begin
                    drain_results();
                    apb_write(rcpw_pkg::REG_PHASE_STEP, $urandom);
                end
                send_sample(random_sample());
            end
        end
    endtask

    always @(negedge i_clk) begin
        case ((rx_cycle / 300) % 4)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= ($urandom_range(0, 3) != 0);
            2: i_m_tready <= ((rx_cycle % 7) >= 3);
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    i_m_tready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_hold = $urandom_range(1, 20);
                    i_m_tready <= 1'b0;
                end else begin
                    i_m_tready <= 1'b1;
                end
            end
        endcase
        rx_cycle++;
    end

    always @(posedge i_clk) begin
        t_windowed_word got;
        t_windowed_word want;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            got.windowed = o_m_tdata;
            got.last     = o_m_tlast;
            if (pending_windowed.size() == 0) begin
                note_mismatch("word with nothing expected", '0, got);
            end else begin
                want = pending_windowed.pop_front();
                if (got.windowed !== want.windowed || got.last !== want.last) begin
                    note_mismatch("windowed word", want, got);
                end
            end
        end
    end

    initial begin
        build_cos_rom();
        reset_model();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);
        test_reset_extremes();
        test_half_length_zero();
        test_saturation_and_early_end();
        test_step_change_mid_packet();
        test_random_packets();
        drain_results();
        if (mismatch_count == 0 && pending_windowed.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
